// ===== design/psss_pkg.sv =====
// ----------------------------------------------------------------------------
// psss_pkg
// shared types and constants of the partial shuffle subset sampler
// ----------------------------------------------------------------------------
package psss_pkg;

  localparam int WORD_W      = 32;
  localparam int IDX_W       = 6;
  localparam int POP_W       = 7;
  localparam int SUB_W       = 6;
  localparam int POS_MAX_W   = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [POP_W-1:0] POP_RESET = 7'd64;
  localparam logic [SUB_W-1:0] SUB_RESET = 6'd1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_IDLE = 1'b1;

  localparam logic REG_POP = 1'b0;
  localparam logic REG_SUB = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic                 idle;
    logic                 start;
    logic [IDX_W-1:0]     skip;
    logic [WORD_W-1:0]    word;
    logic [POS_MAX_W-1:0] pos;
    logic [POS_MAX_W-1:0] rem;
    logic                 swap;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             status;
  } res_t;

endpackage

// ===== design/psss_front.sv =====
// ----------------------------------------------------------------------------
// psss_front
// accepts requests, tracks the draw position and classifies each request
// ----------------------------------------------------------------------------
module psss_front #(
  parameter int MAX_POPULATION = 64,
  parameter int RANDOM_BITS    = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           start_req,
  input  logic [psss_pkg::IDX_W-1:0]     excluded_index,
  input  logic [psss_pkg::WORD_W-1:0]    random_word,
  input  logic [psss_pkg::POP_W-1:0]     pop_cfg,
  input  logic [psss_pkg::SUB_W-1:0]     sub_cfg,
  input  logic                           q_full,
  output logic                           q_push,
  output psss_pkg::cmd_t                 q_cmd
);

  localparam int PW = $clog2(MAX_POPULATION);
  localparam int EW = PW + 1;
  localparam int CW = (EW > psss_pkg::POP_W) ? EW : psss_pkg::POP_W;
  localparam int RW = (RANDOM_BITS < psss_pkg::WORD_W) ? RANDOM_BITS : psss_pkg::WORD_W;
  localparam logic [psss_pkg::WORD_W-1:0] WORD_MASK =
    psss_pkg::WORD_W'((64'd1 << RW) - 64'd1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_POPULATION);

  logic          active_r, active_nxt;
  logic [PW-1:0] step_r, step_nxt;

  logic [CW-1:0] pop_ext, pop_eff, popm1, sub_ext, eff, p_cur, rem;
  logic          accept, active, swap, last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    pop_ext = CW'(pop_cfg);
    if (pop_ext < CW'(2)) begin
      pop_eff = CW'(2);
    end else if (pop_ext > MAX_C) begin
      pop_eff = MAX_C;
    end else begin
      pop_eff = pop_ext;
    end
    popm1   = pop_eff - CW'(1);
    sub_ext = CW'(sub_cfg);
    eff     = (sub_ext == '0) ? CW'(1) : sub_ext;
    if (eff > popm1) begin
      eff = popm1;
    end
    active = start_req || active_r;
    p_cur  = start_req ? '0 : CW'(step_r);
    swap   = p_cur < popm1;
    rem    = popm1 - p_cur;
    last   = !swap || ((p_cur + CW'(1)) >= eff);
  end

  always_comb begin
    q_cmd.idle  = !active;
    q_cmd.start = start_req;
    q_cmd.skip  = excluded_index;
    q_cmd.word  = random_word & WORD_MASK;
    q_cmd.pos   = psss_pkg::POS_MAX_W'(p_cur);
    q_cmd.rem   = psss_pkg::POS_MAX_W'(rem);
    q_cmd.swap  = swap;
    q_cmd.last  = last;
  end

  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    if (accept && active) begin
      if (last) begin
        active_nxt = 1'b0;
        step_nxt   = '0;
      end else begin
        active_nxt = 1'b1;
        step_nxt   = PW'(p_cur + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
    end
  end

endmodule

// ===== design/psss_queue.sv =====
// ----------------------------------------------------------------------------
// psss_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module psss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psss_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output psss_pkg::cmd_t pop_cmd
);

  psss_pkg::cmd_t                    slot_r [psss_pkg::QUEUE_DEPTH];
  logic [psss_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [psss_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full    = cnt_r == psss_pkg::QCNT_W'(psss_pkg::QUEUE_DEPTH);
  assign valid   = cnt_r != '0;
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + psss_pkg::QCNT_W'(push) - psss_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/psss_mod.sv =====
// ----------------------------------------------------------------------------
// psss_mod
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module psss_mod #(
  parameter int RW = 32,
  parameter int PW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic          done,
  output logic [PW-1:0] remainder
);

  localparam int CNT_W = $clog2(RW + 1);

  logic [RW-1:0]    shift_r, shift_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PW:0]      trial, diff;

  assign done      = done_r;
  assign remainder = rem_r;

  always_comb begin
    trial     = {rem_r, shift_r[RW-1]};
    diff      = trial - {1'b0, div_r};
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
      cnt_nxt   = CNT_W'(RW);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = shift_r << 1;
      rem_nxt   = (trial >= {1'b0, div_r}) ? diff[PW-1:0] : trial[PW-1:0];
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");
`endif

endmodule

// ===== design/psss_back.sv =====
// ----------------------------------------------------------------------------
// psss_back
// runs each request: modulo and table swap where the step swaps, result hand-off
// ----------------------------------------------------------------------------
module psss_back #(
  parameter int MAX_POPULATION = 64,
  parameter int RANDOM_BITS    = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  psss_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output psss_pkg::res_t res
);

  localparam int PW = $clog2(MAX_POPULATION);
  localparam int EW = PW + 1;
  localparam int CW = (EW > psss_pkg::POP_W) ? EW : psss_pkg::POP_W;
  localparam int RW = (RANDOM_BITS < psss_pkg::WORD_W) ? RANDOM_BITS : psss_pkg::WORD_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_RD   = 6'b000100,
    S_WRP  = 6'b001000,
    S_WRJ  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [PW-1:0]                   p_r, p_nxt, j_r, j_nxt;
  logic                            last_r, last_nxt;
  logic [psss_pkg::IDX_W-1:0]      skip_r, skip_nxt;
  logic [MAX_POPULATION-1:0]       valid_r, valid_nxt;
  logic [EW-1:0]                   hold_a_r, hold_a_nxt;
  psss_pkg::res_t                  pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  psss_pkg::res_t                  out_r, out_nxt;

  logic [EW-1:0] mem [MAX_POPULATION];
  logic [EW-1:0] rd_a_r, rd_b_r;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic          mod_start, mod_done;
  logic [PW-1:0] mod_rem;

  logic [EW-1:0] va, vb;
  logic [CW-1:0] vb_ext;

  // unwritten entry k stands for member k, or k+1 at and above the skipped one
  function automatic logic [EW-1:0] dflt(input logic [PW-1:0] k,
                                         input logic [psss_pkg::IDX_W-1:0] s);
    logic [CW-1:0] ke, se;
    ke = CW'(k);
    se = CW'(s);
    dflt = (ke < se) ? EW'(ke) : EW'(ke + CW'(1));
  endfunction

  psss_mod #(.RW(RW), .PW(PW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (q_cmd.word[RW-1:0]),
    .divisor  (q_cmd.rem[PW-1:0]),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  assign va        = valid_r[p_r] ? rd_a_r : dflt(p_r, skip_r);
  assign vb        = valid_r[j_r] ? rd_b_r : dflt(j_r, skip_r);
  assign vb_ext    = CW'(vb);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    skip_nxt      = skip_r;
    valid_nxt     = valid_r;
    hold_a_nxt    = hold_a_r;
    pend_nxt      = pend_r;
    q_pop         = 1'b0;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = p_r;
    mem_wdata     = vb;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          p_nxt    = q_cmd.pos[PW-1:0];
          j_nxt    = q_cmd.pos[PW-1:0];
          last_nxt = q_cmd.last;
          if (q_cmd.start) begin
            valid_nxt = '0;
            skip_nxt  = q_cmd.skip;
          end
          if (q_cmd.idle) begin
            pend_nxt.idx    = '0;
            pend_nxt.last   = 1'b0;
            pend_nxt.status = psss_pkg::STATUS_IDLE;
            state_nxt       = S_OUT;
          end else if (q_cmd.swap) begin
            mod_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            // position at or past the last entry of the population: no swap, entry read as is
            state_nxt = S_RD;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          j_nxt     = p_r + mod_rem;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WRP;
      end
      S_WRP: begin
        mem_we          = 1'b1;
        mem_waddr       = p_r;
        mem_wdata       = vb;
        valid_nxt[p_r]  = 1'b1;
        hold_a_nxt      = va;
        pend_nxt.idx    = vb_ext[psss_pkg::IDX_W-1:0];
        pend_nxt.last   = last_r;
        pend_nxt.status = psss_pkg::STATUS_OK;
        state_nxt       = S_WRJ;
      end
      S_WRJ: begin
        mem_we         = 1'b1;
        mem_waddr      = j_r;
        mem_wdata      = hold_a_r;
        valid_nxt[j_r] = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_RD) begin
      rd_a_r <= mem[p_r];
      rd_b_r <= mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    j_r      <= j_nxt;
    last_r   <= last_nxt;
    skip_r   <= skip_nxt;
    hold_a_r <= hold_a_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRJ) |-> (j_r >= p_r))
    else $error("swap partner below step position");

  a_pos_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRP) |=> valid_r[p_r])
    else $error("written position not marked valid");
`endif

endmodule

// ===== design/partial_shuffle_subset_sampler.sv =====
// ----------------------------------------------------------------------------
// partial_shuffle_subset_sampler
// flow: an accepted request waits in the queue, then the back end runs the
//   modulo (swap only), reads the table, writes both entries and registers the result
// throughput: the back end finishes one request before it takes the next, held
//   up by the bit-serial modulo unit and the single write port of the index table;
//   idle requests skip the modulo and the table, steps without swap the modulo
// reset: synchronous active-low rst_n clears control state, no draw active,
//   registers back to population 64 and subset 1; no clearing pass is needed
// ----------------------------------------------------------------------------
module partial_shuffle_subset_sampler #(
  parameter int MAX_POPULATION = 64,
  parameter int RANDOM_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // excluded_index[5:0], random_word[37:6], zero pad
  input  logic [0:0]  in_tuser,   // start_req
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // chosen_index[5:0], zero pad
  output logic        out_tlast,  // last
  output logic [0:0]  out_tuser,  // status
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // registers
  logic [psss_pkg::POP_W-1:0] pop_r, pop_nxt;
  logic [psss_pkg::SUB_W-1:0] sub_r, sub_nxt;
  logic                       cfg_wr;

  // front to queue to back
  logic           q_push, q_full, q_valid, q_pop;
  psss_pkg::cmd_t push_cmd, pop_cmd;
  psss_pkg::res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register index is the word address bit
  always_comb begin
    pop_nxt = pop_r;
    sub_nxt = sub_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        psss_pkg::REG_POP: pop_nxt = cfg_pwdata[psss_pkg::POP_W-1:0];
        psss_pkg::REG_SUB: sub_nxt = cfg_pwdata[psss_pkg::SUB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      psss_pkg::REG_POP: cfg_prdata = 32'(pop_r);
      psss_pkg::REG_SUB: cfg_prdata = 32'(sub_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r <= psss_pkg::POP_RESET;
      sub_r <= psss_pkg::SUB_RESET;
    end else begin
      pop_r <= pop_nxt;
      sub_r <= sub_nxt;
    end
  end

  // front: accepts requests, saturates the counts and tracks the step position
  psss_front #(
    .MAX_POPULATION(MAX_POPULATION),
    .RANDOM_BITS   (RANDOM_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .start_req     (in_tuser[0]),
    .excluded_index(in_tdata[5:0]),
    .random_word   (in_tdata[37:6]),
    .pop_cfg       (pop_r),
    .sub_cfg       (sub_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // short queue lets the front keep taking requests while the back works
  psss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_cmd (pop_cmd)
  );

  // back: modulo, swap in the index table, registered result
  psss_back #(
    .MAX_POPULATION(MAX_POPULATION),
    .RANDOM_BITS   (RANDOM_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {2'b00, res.idx};
  assign out_tlast = res.last;
  assign out_tuser = res.status;

endmodule

// ===== tb/sv/psss_draw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psss_draw_checker
// watches request, result and register traffic of the subset sampler, keeps
// its own shuffle table, predicts every result and compares them in order
// ----------------------------------------------------------------------------
module psss_draw_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // excluded_index[5:0], random_word[37:6], zero pad
  input  logic [0:0]  in_tuser,   // start_req
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // chosen_index[5:0], zero pad
  input  logic        out_tlast,  // last
  input  logic [0:0]  out_tuser,  // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  localparam int TABLE_DEPTH = 64;

  logic [psss_pkg::POP_W-1:0] pop_reg;
  logic [psss_pkg::SUB_W-1:0] sub_reg;
  logic [psss_pkg::IDX_W-1:0] shuffle_tab [TABLE_DEPTH];
  bit                         shuffle_set [TABLE_DEPTH];
  int unsigned                draw_pos;
  bit                         draw_on;
  logic [psss_pkg::IDX_W-1:0] skip_idx;
  psss_pkg::res_t             expected_picks [$];

  // entries never written stand for the identity with the skipped member left out
  function automatic logic [psss_pkg::IDX_W-1:0] table_entry(int unsigned k);
    if (shuffle_set[k]) return shuffle_tab[k];
    if (k < skip_idx) return psss_pkg::IDX_W'(k);
    return psss_pkg::IDX_W'(k + 1);
  endfunction

  function automatic void table_write(int unsigned k, logic [psss_pkg::IDX_W-1:0] v);
    shuffle_tab[k] = v;
    shuffle_set[k] = 1'b1;
  endfunction

  function automatic psss_pkg::res_t draw_step(logic st,
                                               logic [psss_pkg::IDX_W-1:0] ex,
                                               logic [psss_pkg::WORD_W-1:0] w);
    psss_pkg::res_t             r;
    int unsigned                pop;
    int unsigned                popm1;
    int unsigned                eff;
    int unsigned                p;
    int unsigned                j;
    int unsigned                rem;
    logic [psss_pkg::IDX_W-1:0] a;
    logic [psss_pkg::IDX_W-1:0] b;
    logic                       fin;
    if (st) begin
      foreach (shuffle_set[k]) shuffle_set[k] = 1'b0;
      skip_idx = ex;
      draw_pos = 0;
      draw_on  = 1'b1;
    end
    if (!draw_on) begin
      r.idx    = '0;
      r.last   = 1'b0;
      r.status = psss_pkg::STATUS_IDLE;
      return r;
    end
    pop = pop_reg;
    if (pop < 2) pop = 2;
    if (pop > TABLE_DEPTH) pop = TABLE_DEPTH;
    popm1 = pop - 1;
    eff   = (sub_reg == 0) ? 1 : sub_reg;
    if (eff > popm1) eff = popm1;
    p = draw_pos;
    if (p < popm1) begin
      rem = popm1 - p;
      j   = p + (w % rem);
      a   = table_entry(p);
      b   = table_entry(j);
      table_write(p, b);
      table_write(j, a);
      fin = (p + 1 >= eff);
    end else begin
      // population shrank below the position: no swap, draw ends here
      fin = 1'b1;
    end
    r.idx    = table_entry(p);
    r.last   = fin;
    r.status = psss_pkg::STATUS_OK;
    if (fin) begin
      draw_on  = 1'b0;
      draw_pos = 0;
    end else begin
      draw_pos = p + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    psss_pkg::res_t want;
    if (!rst_n) begin
      pop_reg    = psss_pkg::POP_RESET;
      sub_reg    = psss_pkg::SUB_RESET;
      draw_on    = 1'b0;
      draw_pos   = 0;
      skip_idx   = '0;
      fail_count = 0;
      foreach (shuffle_set[k]) shuffle_set[k] = 1'b0;
      expected_picks.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          psss_pkg::REG_POP: pop_reg = cfg_pwdata[psss_pkg::POP_W-1:0];
          psss_pkg::REG_SUB: sub_reg = cfg_pwdata[psss_pkg::SUB_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_picks.push_back(draw_step(in_tuser[0], in_tdata[psss_pkg::IDX_W-1:0],
                                           in_tdata[psss_pkg::IDX_W +: psss_pkg::WORD_W]));
      if (out_tvalid && out_tready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: result with no request pending: index %0d last %0b status %0b",
                   $time, out_tdata[psss_pkg::IDX_W-1:0], out_tlast, out_tuser[0]);
          fail_count = fail_count + 1;
        end else begin
          want = expected_picks.pop_front();
          if (out_tdata[psss_pkg::IDX_W-1:0] !== want.idx) begin
            $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                     $time, want.idx, out_tdata[psss_pkg::IDX_W-1:0]);
            fail_count = fail_count + 1;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_tlast);
            fail_count = fail_count + 1;
          end
          if (out_tuser[0] !== want.status) begin
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, want.status, out_tuser[0]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending <= expected_picks.size();
  end

endmodule

// ===== tb/sv/partial_shuffle_subset_sampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_shuffle_subset_sampler_tb
// drives draw requests and register writes into the subset sampler, with
// random gaps on both channels and one long result stall; a separate checker
// predicts every drawn index and this top gives the verdict
// ----------------------------------------------------------------------------
module partial_shuffle_subset_sampler_tb;

  localparam int HOLD_AT        = 300;   // result count at which the sink stalls
  localparam int HOLD_LEN       = 400;   // length of that stall in cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam int DRAIN_CYCLES   = 50;    // beyond the longest request latency
  localparam int NUM_PHASES     = 11;
  localparam int PHASE_ITEMS    = 120;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;   // excluded_index[5:0], random_word[37:6], zero pad
  logic [0:0]  in_tuser    = '0;   // start_req
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;          // chosen_index[5:0], zero pad
  logic        out_tlast;          // last
  logic [0:0]  out_tuser;          // status
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int stuck_cycles = 0;
  bit quiet        = 1'b0;   // both sides run back to back while set
  int shape_pop    = 64;     // last written settings, only used to shape draws
  int shape_sub    = 1;

  always #6 clk = ~clk;

  partial_shuffle_subset_sampler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  psss_draw_checker draw_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // gap before each request or result, none during quiet phases
  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // random word with extra weight on all zeros, all ones and small values
  function automatic logic [psss_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return psss_pkg::WORD_W'($urandom_range(0, 63));
      default: return $urandom();
    endcase
  endfunction

  // one request: optional gap, then hold tvalid until the handshake edge
  task automatic send_request(input logic st, input logic [psss_pkg::IDX_W-1:0] ex,
                              input logic [psss_pkg::WORD_W-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= st;
    in_tdata  <= {2'b00, w, ex};
    do @(posedge clk); while (!in_tready);
  endtask

  // setup cycle then access cycle; psel stays high so writes can follow back to back
  task automatic write_reg(input logic sel, input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // registers change only once every result in flight has come back
  task automatic set_config(input int unsigned pop, input int unsigned sub);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    write_reg(psss_pkg::REG_POP, pop);
    write_reg(psss_pkg::REG_SUB, sub);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shape_pop = pop;
    shape_sub = sub;
  endtask

  // result sink: random stalls, plus one long hold so the request side backs up
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_LEN : pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // watchdog on any handshake, register writes included
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      stuck_cycles = 0;
    else
      stuck_cycles = stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int                         mode;
    int                         len;
    int                         pop_eff;
    int                         sub_eff;
    int                         draw_items;
    logic [psss_pkg::IDX_W-1:0] ex;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle requests before any draw has started
    send_request(1'b0, 6'd63, 32'hFFFF_FFFF);
    send_request(1'b0, 6'd0, 32'h0);
    // reset settings: one index per draw, excluded member at both ends
    send_request(1'b1, 6'd0, 32'h0);
    send_request(1'b1, 6'd63, 32'hFFFF_FFFF);
    // population and subset below their minimum act as 2 and 1
    set_config(0, 0);
    send_request(1'b1, 6'd1, 32'hFFFF_FFFF);
    send_request(1'b1, 6'd0, 32'h8000_0000);
    // excluded member outside the population, so nothing is skipped
    send_request(1'b1, 6'd40, 32'h0000_0007);
    // oversized population clamps to the table size, subset at its top
    set_config(127, 63);
    send_request(1'b1, 6'd17, 32'h0123_4567);
    repeat (3) send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    // population shrinks under a running draw, first still above the position
    set_config(10, 9);
    send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    // then below it: no swap, the current entry comes out as last
    set_config(4, 9);
    send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    // subset shrinks under a running draw, which ends on the next step
    set_config(12, 9);
    send_request(1'b1, 6'd3, rand_word());
    repeat (3) send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    set_config(12, 2);
    send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    // a start in the middle of a draw throws the old table away
    set_config(64, 5);
    send_request(1'b1, 6'd5, rand_word());
    send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
    send_request(1'b1, 6'd60, rand_word());
    repeat (3) send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());

    // random phases: mostly whole draws, some cut short, some stray requests
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(64, 63);
        1:       set_config(2, 1);
        2:       set_config(64, 1);
        3:       set_config(1, 0);
        4:       set_config(127, 40);
        default: set_config($urandom_range(0, 127), $urandom_range(0, 63));
      endcase
      quiet <= (ph % 4 == 3);
      pop_eff = (shape_pop < 2) ? 2 : (shape_pop > 64) ? 64 : shape_pop;
      sub_eff = (shape_sub < 1) ? 1 : shape_sub;
      if (sub_eff > pop_eff - 1) sub_eff = pop_eff - 1;
      draw_items = 0;
      while (draw_items < PHASE_ITEMS) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          // stray step: idle, or continues whatever draw is left open
          send_request(1'b0, psss_pkg::IDX_W'($urandom), rand_word());
        end else begin
          len = (mode == 1) ? $urandom_range(1, sub_eff) : sub_eff;
          ex  = ($urandom_range(0, 3) == 0) ?
                psss_pkg::IDX_W'($urandom_range(0, 63)) :
                psss_pkg::IDX_W'($urandom_range(0, pop_eff - 1));
          for (int s = 0; s < len; s++)
            send_request(s == 0, ex, rand_word());
          draw_items += len;
        end
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
